// ===== hdl/clrg_pkg.sv =====
// ----------------------------------------------------------------------------
// clrg_pkg
// Constants, register codes and step functions shared by the combined
// congruential generator.
// ----------------------------------------------------------------------------
`default_nettype none

package clrg_pkg;

	localparam int unsigned VAL_W  = 31;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;

	localparam logic [VAL_W-1:0] MOD_ONE     = 31'd2147483563;
	localparam logic [VAL_W-1:0] MOD_TWO     = 31'd2147483399;
	localparam logic [15:0]      MUL_ONE     = 16'd40014;
	localparam logic [15:0]      MUL_TWO     = 16'd40692;
	localparam logic [VAL_W-1:0] SEED_ONE_HI = 31'd2147483562;
	localparam logic [VAL_W-1:0] SEED_TWO_HI = 31'd2147483398;
	localparam logic [VAL_W-1:0] SEED_ONE_RST = 31'd55555;
	localparam logic [VAL_W-1:0] SEED_TWO_RST = 31'd99999;

	typedef enum logic {
		REG_SEED_ONE = 1'b0,
		REG_SEED_TWO = 1'b1
	} reg_idx_t;

	// Masked to 31 bits, then saturated into 1..hi.
	function automatic logic [VAL_W-1:0] clamp_seed(input logic [DATA_W-1:0] w,
			input logic [VAL_W-1:0] hi);
		logic [VAL_W-1:0] x;
		x = w[VAL_W-1:0];
		if (x == '0)
			x = 31'd1;
		if (x > hi)
			x = hi;
		return x;
	endfunction

	// s * 40014 mod (2^31 - 85): fold the upper part back in times 85.
	function automatic logic [VAL_W-1:0] step_one(input logic [VAL_W-1:0] s);
		logic [46:0] p;
		logic [15:0] hi;
		logic [31:0] t;
		p  = 47'(s) * 47'(MUL_ONE);
		hi = p[46:31];
		t  = 32'(p[30:0]) + (32'(hi) << 6) + (32'(hi) << 4) + (32'(hi) << 2) + 32'(hi);
		if (t >= 32'(MOD_ONE))
			t = t - 32'(MOD_ONE);
		return t[VAL_W-1:0];
	endfunction

	// s * 40692 mod (2^31 - 249): fold the upper part back in times 249.
	function automatic logic [VAL_W-1:0] step_two(input logic [VAL_W-1:0] s);
		logic [46:0] p;
		logic [15:0] hi;
		logic [31:0] t;
		p  = 47'(s) * 47'(MUL_TWO);
		hi = p[46:31];
		t  = 32'(p[30:0]) + (32'(hi) << 8) - (32'(hi) << 3) + 32'(hi);
		if (t >= 32'(MOD_TWO))
			t = t - 32'(MOD_TWO);
		return t[VAL_W-1:0];
	endfunction

	// a - MOD_ONE + b, wrapped up by MOD_ONE - 1 when below one.
	function automatic logic [VAL_W-1:0] combine(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [31:0] d;
		logic [31:0] r;
		d = 32'(a) + 32'(b);
		if (d > 32'(MOD_ONE))
			r = d - 32'(MOD_ONE);
		else
			r = d - 32'd1;
		return r[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/clrg_draw_if.sv =====
// ----------------------------------------------------------------------------
// clrg_draw_if
// Draw request channel: valid/ready with a one-bit draw word.
// ----------------------------------------------------------------------------
`default_nettype none

interface clrg_draw_if;
	logic valid;
	logic ready;
	logic draw;

	modport source (output valid, output draw, input ready);
	modport sink   (input valid, input draw, output ready);
	modport mon    (input valid, input draw, input ready);
endinterface

`default_nettype wire

// ===== hdl/clrg_value_if.sv =====
// ----------------------------------------------------------------------------
// clrg_value_if
// Result channel: valid/ready with a 31-bit random value word.
// ----------------------------------------------------------------------------
`default_nettype none

interface clrg_value_if
	import clrg_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
	modport mon    (input valid, input value, input ready);
endinterface

`default_nettype wire

// ===== hdl/combined_lcg_random_generator.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_random_generator
// Two multiplicative congruential generators combined into one 31-bit value.
// ----------------------------------------------------------------------------
// Path: an accepted draw word advances the states into stage 1, and stage 2 then holds its combined value word.
// Throughput: one word per cycle while rsp.ready is high; the generator update (one 31x16
//   constant multiply, fold and conditional subtract) is combinational.
// Reset (arst_n low, asynchronous): seeds and generator states return to
//   55555 and 99999, both pipeline stages empty.
// Draw words with draw low are taken and give no value.
`default_nettype none

module combined_lcg_random_generator
	import clrg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	clrg_draw_if.sink              req,
	clrg_value_if.source           rsp
);

	// seed registers (read back) and live generator states
	logic [VAL_W-1:0] seed_one_q, seed_two_q;
	logic [VAL_W-1:0] gen_one_q, gen_two_q;

	// stage 1: freshly advanced states
	logic             vld_s1;
	logic [VAL_W-1:0] gen_one_s1, gen_two_s1;

	// stage 2: combined value word
	logic             vld_s2;
	logic [VAL_W-1:0] value_s2;

	logic     adv_s2, adv_s1, take, draw_take;
	logic     wr_en;
	reg_idx_t reg_idx;
	logic [VAL_W-1:0] nxt_one, nxt_two;

	// ---- APB register port -------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;

	always_comb begin
		case (reg_idx)
			REG_SEED_ONE: prdata = DATA_W'(seed_one_q);
			REG_SEED_TWO: prdata = DATA_W'(seed_two_q);
			default:      prdata = '0;
		endcase
	end

	// ---- handshake ---------------------------------------------------------
	// stage 2 frees up when empty or drained; stage 1 likewise into stage 2
	assign adv_s2    = ~vld_s2 | rsp.ready;
	assign adv_s1    = ~vld_s1 | adv_s2;
	assign req.ready = adv_s1;
	assign take      = req.valid & adv_s1;
	assign draw_take = take & req.draw;

	// ---- generator update --------------------------------------------------
	assign nxt_one = step_one(gen_one_q);
	assign nxt_two = step_two(gen_two_q);

	// a seed write loads its generator; writes must come only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= SEED_ONE_RST;
			seed_two_q <= SEED_TWO_RST;
			gen_one_q  <= SEED_ONE_RST;
			gen_two_q  <= SEED_TWO_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SEED_ONE: begin
					seed_one_q <= clamp_seed(pwdata, SEED_ONE_HI);
					gen_one_q  <= clamp_seed(pwdata, SEED_ONE_HI);
				end
				REG_SEED_TWO: begin
					seed_two_q <= clamp_seed(pwdata, SEED_TWO_HI);
					gen_two_q  <= clamp_seed(pwdata, SEED_TWO_HI);
				end
				default: ;
			endcase
		end else if (draw_take) begin
			gen_one_q <= nxt_one;
			gen_two_q <= nxt_two;
		end
	end

	// ---- stage 1 -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= draw_take;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_take) begin
			gen_one_s1 <= nxt_one;
			gen_two_s1 <= nxt_two;
		end
	end

	// ---- stage 2: output register ------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			value_s2 <= combine(gen_one_s1, gen_two_s1);
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.value = value_s2;

endmodule

`default_nettype wire

// ===== hdl/clrg_checker.sv =====
// ----------------------------------------------------------------------------
// clrg_checker
// Port-level checks on the combined generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clrg_checker
	import clrg_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             pready,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             req_draw,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic [VAL_W-1:0] rsp_value
);

	// every value word lies in 1..MOD_ONE-1
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_value != '0) && (rsp_value <= SEED_ONE_HI))
		else $error("value word out of range");

	// a stalled value word holds
	a_value_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("value word changed while stalled");

	// a value word appearing on an empty output came from an accepted draw with draw high
	a_value_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready && req_draw, 2))
		else $error("value word without matching draw");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind combined_lcg_random_generator clrg_checker u_clrg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_draw  (req.draw),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);

`default_nettype wire
